### src/mraf_pkg.sv
// shared constants, types and helper functions for the measurement record formatter
`default_nettype none
package mraf_pkg;

  // field widths
  localparam int PULSE_W  = 22;
  localparam int ADC_W    = 8;
  localparam int NUM_ADC  = 6;
  localparam int ADC_IW   = $clog2(NUM_ADC);
  localparam int PERIOD_W = 16;
  localparam int REC_W    = 16;
  localparam int ELAPSED_W = 32;
  localparam int RATE_W   = 16;
  localparam int PMS_W    = 14;
  localparam int DIV_W    = 32;
  localparam int CHAR_W   = 8;
  localparam int DEC_W    = 17;
  localparam int IN_TDATA_W = ((PULSE_W + NUM_ADC * ADC_W + 7) / 8) * 8;

  // defaults and arithmetic constants
  localparam int CHANNELS_DEF = 6;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET  = 16'd7812;
  localparam logic [PERIOD_W-1:0] TICKS_PER_SEC = 16'd7812;
  localparam logic [DIV_W-1:0]    MS_PER_SEC    = 32'd1000;
  localparam logic [RATE_W-1:0]   RATE_SAT      = 16'hFFFF;

  // period in ms = (ticks * PMS_RECIP) >> PMS_SHIFT, exact floor of ticks*1000/7812
  // for every 16-bit tick count
  localparam int RECIP_W   = 25;
  localparam int PROD_W    = PERIOD_W + RECIP_W;
  localparam int PMS_SHIFT = 27;
  localparam logic [RECIP_W-1:0] PMS_RECIP = 25'd17180969;

  // line layout
  localparam int HEAD_LEN = 22;

  // ascii codes
  localparam logic [CHAR_W-1:0] CH_CR   = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_LF   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_TAB  = 8'h09;
  localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE = 8'h39;
  localparam logic [CHAR_W-1:0] HEX_ALPHA_OFS = 8'h07;

  // character kinds
  localparam logic [2:0] CK_CR  = 3'd0;
  localparam logic [2:0] CK_LF  = 3'd1;
  localparam logic [2:0] CK_TAB = 3'd2;
  localparam logic [2:0] CK_DEC = 3'd3;
  localparam logic [2:0] CK_HEX = 3'd4;

  // decimal value sources
  localparam logic [1:0] SRC_REC  = 2'd0;
  localparam logic [1:0] SRC_RATE = 2'd1;
  localparam logic [1:0] SRC_ADC  = 2'd2;

  // decimal place selectors
  localparam logic [2:0] POW_1     = 3'd0;
  localparam logic [2:0] POW_10    = 3'd1;
  localparam logic [2:0] POW_100   = 3'd2;
  localparam logic [2:0] POW_1000  = 3'd3;
  localparam logic [2:0] POW_10000 = 3'd4;

  typedef struct packed {
    logic              load;        // take the input word, bump record count
    logic              div_start;   // rate division: pulses*1000 / period_ms
    logic              cap_period;  // add the period in ms to the elapsed time
    logic              cap_rate;
    logic              emit;        // load the next character into the output register
    logic [2:0]        kind;
    logic              first;       // first digit of a decimal field
    logic [1:0]        src;
    logic [ADC_IW-1:0] adc_idx;
    logic [2:0]        pow_sel;
    logic [2:0]        nib_idx;
    logic              last;
  } mraf_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_busy;
  } mraf_stat_t;

  function automatic logic [DEC_W-1:0] pow10(input logic [2:0] sel);
    logic [DEC_W-1:0] p;
    case (sel)
      POW_1:     p = 17'd1;
      POW_10:    p = 17'd10;
      POW_100:   p = 17'd100;
      POW_1000:  p = 17'd1000;
      POW_10000: p = 17'd10000;
      default:   p = 17'd1;
    endcase
    return p;
  endfunction

  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
    logic [CHAR_W-1:0] c;
    c = CH_ZERO + CHAR_W'(nib);
    if (c > CH_NINE) c = c + HEX_ALPHA_OFS;
    return c;
  endfunction

endpackage
`default_nettype wire

### src/measurement_record_ascii_formatter.sv
// top level: measurement record ascii formatter, controller plus datapath
// sequence: on an accepted word the elapsed time is updated and the rate division started;
// after the 32-step iterative division the rate is captured and the first character loaded
// a new word is accepted only once the last character of the previous line is loaded;
// one character per cycle leaves once the division finishes, while out_tready is held high
// reset: synchronous active-low, clears record count and elapsed time, period = 7812
`default_nettype none
module measurement_record_ascii_formatter
  import mraf_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF  // channels printed per line, 1..8, at most six exist
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // configuration: period in prescaled timer ticks
  input  wire logic                  cfg_wr_en,
  input  wire logic [PERIOD_W-1:0]   cfg_wr_data,
  // input word, one per measurement period
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // pulse_count[21:0], adc_ch0..adc_ch5 8 bits each from bit 22 up, zero pad [71:70]
  input  wire logic [IN_TDATA_W-1:0] in_tdata,
  // output characters
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [CHAR_W-1:0]          out_tdata,  // tx_byte[7:0]
  output logic                       out_tlast   // line_end
);

  mraf_cmd_t  cmd;
  mraf_stat_t stat;

  // controller walks the record: load (period in ms by reciprocal multiply), elapsed
  // update with the rate division start, rate capture once the division is done, then the
  // line one character at a time as the output register frees up
  mraf_ctrl #(.CHANNELS(CHANNELS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath holds the period register, record and elapsed counters, the divider,
  // the decimal/hex digit logic and the output register
  mraf_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tdata    (in_tdata),
    .cmd         (cmd),
    .stat        (stat),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

endmodule
`default_nettype wire

### src/mraf_div.sv
// iterative restoring divider, one quotient bit per cycle
`default_nettype none
module mraf_div
  import mraf_pkg::*;
#(
  parameter int DW = DIV_W,
  parameter int VW = PMS_W
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output logic      [DW-1:0] quotient,
  output logic               done
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] q_r, q_nxt;
  logic [VW-1:0] rem_r, rem_nxt;
  logic [VW-1:0] den_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          done_r, done_nxt;
  logic [VW:0]   rem_sh;
  logic          ge;

  always_comb begin
    rem_sh   = {rem_r, q_r[DW-1]};
    ge       = rem_sh >= {1'b0, den_r};
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt   = dividend;
      rem_nxt = '0;
      cnt_nxt = CW'(DW);
    end else if (cnt_r != '0) begin
      q_nxt    = {q_r[DW-2:0], ge};
      rem_nxt  = ge ? VW'(rem_sh - {1'b0, den_r}) : rem_sh[VW-1:0];
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) den_r <= divisor;
  end

  assign quotient = q_r;
  assign done     = done_r;

endmodule
`default_nettype wire

### src/mraf_datapath.sv
// datapath: period register, counters, divider, digit and character generation
`default_nettype none
module mraf_datapath
  import mraf_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr_en,
  input  wire logic [PERIOD_W-1:0]   cfg_wr_data,
  input  wire logic [IN_TDATA_W-1:0] in_tdata,
  input  wire mraf_cmd_t             cmd,
  output mraf_stat_t                 stat,
  input  wire logic                  out_tready,
  output logic                       out_tvalid,
  output logic [CHAR_W-1:0]          out_tdata,
  output logic                       out_tlast
);

  logic [PERIOD_W-1:0]  period_r;
  logic [ADC_W-1:0]     adc_r [NUM_ADC];
  logic [REC_W-1:0]     rec_r;
  logic [ELAPSED_W-1:0] elapsed_r;
  logic [PMS_W-1:0]     pms_r;
  logic [RATE_W-1:0]    rate_r;
  logic [DIV_W-1:0]     mul_r;
  logic [REC_W-1:0]     val_r, val_nxt;
  logic                 ov_r;
  logic [CHAR_W-1:0]    char_r, char_nxt;
  logic                 last_r;

  logic [DIV_W-1:0]     quot;
  logic                 div_done;
  logic [PROD_W-1:0]    pms_prod;
  logic [PMS_W-1:0]     pms_calc;

  logic [REC_W-1:0]     cur;
  logic [DEC_W-1:0]     cur_x, pw, rem_x;
  logic [3:0]           digit;
  logic [3:0]           nib;

  // period in ms by reciprocal multiplication of the period register
  assign pms_prod = PROD_W'(period_r) * PROD_W'(PMS_RECIP);
  assign pms_calc = pms_prod[PMS_SHIFT +: PMS_W];

  mraf_div #(.DW(DIV_W), .VW(PMS_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (mul_r),
    .divisor  (pms_r),
    .quotient (quot),
    .done     (div_done)
  );

  // decimal digit: largest d with d*place <= value, then strip it
  always_comb begin
    case (cmd.src)
      SRC_REC:  cur = rec_r;
      SRC_RATE: cur = rate_r;
      SRC_ADC:  cur = REC_W'(adc_r[cmd.adc_idx]);
      default:  cur = rec_r;
    endcase
    if (!cmd.first) cur = val_r;
    cur_x = DEC_W'(cur);
    pw    = pow10(cmd.pow_sel);
    digit = 4'd0;
    for (int d = 1; d <= 9; d++) begin
      if (cur_x >= DEC_W'(d) * pw) digit = 4'(d);
    end
    rem_x   = cur_x - DEC_W'(digit) * pw;
    val_nxt = rem_x[REC_W-1:0];
  end

  always_comb begin
    nib = elapsed_r[{cmd.nib_idx, 2'b00} +: 4];
    case (cmd.kind)
      CK_CR:   char_nxt = CH_CR;
      CK_LF:   char_nxt = CH_LF;
      CK_TAB:  char_nxt = CH_TAB;
      CK_DEC:  char_nxt = CH_ZERO + CHAR_W'(digit);
      CK_HEX:  char_nxt = hex_char(nib);
      default: char_nxt = CH_TAB;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r  <= PERIOD_RESET;
      rec_r     <= '0;
      elapsed_r <= '0;
      ov_r      <= 1'b0;
    end else begin
      if (cfg_wr_en) period_r <= cfg_wr_data;
      if (cmd.load) rec_r <= rec_r + 1'b1;
      if (cmd.cap_period) elapsed_r <= elapsed_r + ELAPSED_W'(pms_r);
      if (cmd.emit) ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < NUM_ADC; i++) begin
        adc_r[i] <= in_tdata[PULSE_W + i*ADC_W +: ADC_W];
      end
      mul_r <= DIV_W'(in_tdata[PULSE_W-1:0]) * MS_PER_SEC;
      pms_r <= pms_calc;
    end
    if (cmd.cap_rate) rate_r <= (pms_r == '0) ? RATE_SAT : quot[RATE_W-1:0];
    if (cmd.emit) begin
      char_r <= char_nxt;
      last_r <= cmd.last;
      if (cmd.kind == CK_DEC) val_r <= val_nxt;
    end
  end

  assign stat.div_done = div_done;
  assign stat.out_busy = ov_r && !out_tready;

  assign out_tvalid = ov_r;
  assign out_tdata  = char_r;
  assign out_tlast  = last_r;

endmodule
`default_nettype wire

### src/mraf_ctrl.sv
// controller: record sequencing and per-character command decode
`default_nettype none
module mraf_ctrl
  import mraf_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire mraf_stat_t stat,
  output mraf_cmd_t       cmd
);

  localparam int NUM_EMIT = (CHANNELS < NUM_ADC) ? CHANNELS : NUM_ADC;
  localparam int LINE_LEN = HEAD_LEN + 4 * NUM_EMIT;
  localparam int CI_W     = $clog2(LINE_LEN);

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_DIVGO   = 2'd1;
  localparam logic [1:0] S_DIVWAIT = 2'd2;
  localparam logic [1:0] S_EMIT    = 2'd3;

  logic [1:0]      state_r, state_nxt;
  logic [CI_W-1:0] ci_r, ci_nxt;
  logic [CI_W-1:0] ofs;
  logic [1:0]      m;
  logic            is_last;

  // character index to layout fields
  always_comb begin
    ofs         = ci_r - CI_W'(HEAD_LEN);
    m           = ofs[1:0];
    is_last     = (ci_r == CI_W'(LINE_LEN - 1));
    cmd         = '0;
    cmd.kind    = CK_TAB;
    cmd.src     = SRC_REC;
    cmd.pow_sel = POW_1;
    if (ci_r == CI_W'(0)) begin
      cmd.kind = CK_CR;
    end else if (ci_r == CI_W'(1)) begin
      cmd.kind = CK_LF;
    end else if (ci_r inside {[2:6]}) begin
      cmd.kind    = CK_DEC;
      cmd.src     = SRC_REC;
      cmd.first   = (ci_r == CI_W'(2));
      cmd.pow_sel = 3'(CI_W'(6) - ci_r);
    end else if (ci_r inside {[8:15]}) begin
      cmd.kind    = CK_HEX;
      cmd.nib_idx = 3'(CI_W'(15) - ci_r);
    end else if (ci_r inside {[17:21]}) begin
      cmd.kind    = CK_DEC;
      cmd.src     = SRC_RATE;
      cmd.first   = (ci_r == CI_W'(17));
      cmd.pow_sel = 3'(CI_W'(21) - ci_r);
    end else if (ci_r >= CI_W'(HEAD_LEN) && m != 2'd0) begin
      cmd.kind    = CK_DEC;
      cmd.src     = SRC_ADC;
      cmd.first   = (m == 2'd1);
      cmd.pow_sel = 3'(2'd3 - m);
      cmd.adc_idx = ADC_IW'(ofs[CI_W-1:2]);
    end
    cmd.last = is_last;

    state_nxt = state_r;
    ci_nxt    = ci_r;
    in_tready = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DIVGO;
        end
      end
      S_DIVGO: begin
        cmd.cap_period = 1'b1;
        cmd.div_start  = 1'b1;
        state_nxt      = S_DIVWAIT;
      end
      S_DIVWAIT: begin
        if (stat.div_done) begin
          cmd.cap_rate = 1'b1;
          ci_nxt       = '0;
          state_nxt    = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!stat.out_busy) begin
          cmd.emit = 1'b1;
          if (is_last) begin
            state_nxt = S_IDLE;
          end else begin
            ci_nxt = ci_r + 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ci_r    <= '0;
    end else begin
      state_r <= state_nxt;
      ci_r    <= ci_nxt;
    end
  end

  a_no_emit_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !stat.out_busy)
    else $error("character loaded over a word not yet taken");

  a_accept_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_DIVGO))
    else $error("accepted word did not start the rate division");

  a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && cmd.last) |=> (state_r == S_IDLE))
    else $error("line end did not return to idle");

  a_index_in_line: assert property (@(posedge clk) disable iff (!rst_n)
    ci_r < CI_W'(LINE_LEN))
    else $error("character index beyond line length");

endmodule
`default_nettype wire
